// ===== src/stable_priority_queue_top_macros.svh =====
// ----------------------------------------------------------------------------
// stable_priority_queue_top_macros.svh
// Assertion macros shared by the priority queue RTL.
// ----------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define SPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that cons holds in the cycle after ante.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg
// Types and codes shared by the priority queue cells and top level.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam logic OP_INSERT  = 1'b0;
   localparam logic OP_EXECUTE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } spq_status_type;

   // Per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins_en;
      logic pop_en;
   } spq_ctrl_type;

endpackage

// ===== src/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds a tag and a priority, and on each
// command either keeps them, takes the new item, or shifts from a neighbour.
// ----------------------------------------------------------------------------
module spq_cell #(
   parameter int PRIO_BITS  = 8,
   parameter int TAG_BITS   = 8,
   parameter int CNT_BITS   = 5,
   parameter int CELL_INDEX = 0
) (
   input  logic                 clock,
   input  spq_pkg::spq_ctrl_type ctrl,
   input  logic [CNT_BITS-1:0]  count,
   input  logic [TAG_BITS-1:0]  new_tag,
   input  logic [PRIO_BITS-1:0] new_prio,
   input  logic                 prev_gt,
   input  logic [TAG_BITS-1:0]  prev_tag,
   input  logic [PRIO_BITS-1:0] prev_prio,
   input  logic [TAG_BITS-1:0]  next_tag,
   input  logic [PRIO_BITS-1:0] next_prio,
   output logic [TAG_BITS-1:0]  tag,
   output logic [PRIO_BITS-1:0] prio,
   output logic                 gt
);

   logic [TAG_BITS-1:0]  tag_ff;
   logic [TAG_BITS-1:0]  tag_in;
   logic [PRIO_BITS-1:0] prio_ff;
   logic [PRIO_BITS-1:0] prio_in;
   logic                 occupied;

   assign occupied = CNT_BITS'(CELL_INDEX) < count;
   // An empty slot ranks behind everything, so the new item lands there
   assign gt = !occupied || (prio_ff > new_prio);

   always_comb begin
      tag_in  = tag_ff;
      prio_in = prio_ff;
      if (ctrl.pop_en) begin
         tag_in  = next_tag;
         prio_in = next_prio;
      end else if (ctrl.ins_en) begin
         if (prev_gt) begin
            tag_in  = prev_tag;
            prio_in = prev_prio;
         end else if (gt) begin
            tag_in  = new_tag;
            prio_in = new_prio;
         end
      end
   end

   always_ff @(posedge clock) begin
      tag_ff  <= tag_in;
      prio_ff <= prio_in;
   end

   assign tag  = tag_ff;
   assign prio = prio_ff;

endmodule

// ===== src/stable_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_top
// Sorted priority queue built as a row of compare-and-shift cells.
// Latency: one result per item, on rsp_valid in the cycle after acceptance.
// Throughput: one item per cycle; busy stays low, set by the compare and shift
// across the cell row, which every cell completes into its registers together.
// Reset clears the pending count and the result strobe; cell contents are
// left as they are and only slots below the count are ever read.
// ----------------------------------------------------------------------------
`include "stable_priority_queue_top_macros.svh"

module stable_priority_queue_top #(
   parameter int QUEUE_DEPTH = 16,
   parameter int PRIO_BITS   = 8,
   parameter int TAG_BITS    = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [TAG_BITS-1:0]                req_process_tag,
   input  logic [PRIO_BITS-1:0]               req_prio,
   output logic                               rsp_valid,
   output logic [1:0]                         rsp_status,
   output logic                               rsp_served_valid,
   output logic [TAG_BITS-1:0]                rsp_served_tag,
   output logic [PRIO_BITS-1:0]               rsp_served_prio,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]   rsp_pending_count
);
   import spq_pkg::*;

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_BITS-1:0] FULL_COUNT = CNT_BITS'(QUEUE_DEPTH);

   logic [TAG_BITS-1:0]  cell_tag  [QUEUE_DEPTH];
   logic [PRIO_BITS-1:0] cell_prio [QUEUE_DEPTH];
   logic                 cell_gt   [QUEUE_DEPTH];

   spq_ctrl_type         ctrl;
   logic                 is_full;
   logic                 is_empty;

   logic [CNT_BITS-1:0]  count_ff;
   logic [CNT_BITS-1:0]  count_in;
   logic                 rsp_valid_ff;
   spq_status_type       status_ff;
   spq_status_type       status_in;
   logic                 served_valid_ff;
   logic [TAG_BITS-1:0]  served_tag_ff;
   logic [TAG_BITS-1:0]  served_tag_in;
   logic [PRIO_BITS-1:0] served_prio_ff;
   logic [PRIO_BITS-1:0] served_prio_in;

   assign busy     = 1'b0;
   assign is_full  = count_ff == FULL_COUNT;
   assign is_empty = count_ff == '0;

   assign ctrl.ins_en = start && (req_op == OP_INSERT) && !is_full;
   assign ctrl.pop_en = start && (req_op == OP_EXECUTE) && !is_empty;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      logic                 prev_gt;
      logic [TAG_BITS-1:0]  prev_tag;
      logic [PRIO_BITS-1:0] prev_prio;
      logic [TAG_BITS-1:0]  next_tag;
      logic [PRIO_BITS-1:0] next_prio;

      if (i == 0) begin : g_head
         assign prev_gt   = 1'b0;
         assign prev_tag  = req_process_tag;
         assign prev_prio = req_prio;
      end else begin : g_body
         assign prev_gt   = cell_gt[i-1];
         assign prev_tag  = cell_tag[i-1];
         assign prev_prio = cell_prio[i-1];
      end

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         // Tail slot falls out of range on a pop; hold its contents
         assign next_tag  = cell_tag[i];
         assign next_prio = cell_prio[i];
      end else begin : g_inner
         assign next_tag  = cell_tag[i+1];
         assign next_prio = cell_prio[i+1];
      end

      spq_cell #(
         .PRIO_BITS  (PRIO_BITS),
         .TAG_BITS   (TAG_BITS),
         .CNT_BITS   (CNT_BITS),
         .CELL_INDEX (i)
      ) u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .count     (count_ff),
         .new_tag   (req_process_tag),
         .new_prio  (req_prio),
         .prev_gt   (prev_gt),
         .prev_tag  (prev_tag),
         .prev_prio (prev_prio),
         .next_tag  (next_tag),
         .next_prio (next_prio),
         .tag       (cell_tag[i]),
         .prio      (cell_prio[i]),
         .gt        (cell_gt[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.ins_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctrl.pop_en) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      status_in      = STATUS_OK;
      served_tag_in  = '0;
      served_prio_in = '0;
      if (req_op == OP_INSERT) begin
         if (is_full) begin
            status_in = STATUS_FULL;
         end
      end else if (is_empty) begin
         status_in = STATUS_EMPTY;
      end else begin
         served_tag_in  = cell_tag[0];
         served_prio_in = cell_prio[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         status_ff       <= status_in;
         served_valid_ff <= ctrl.pop_en;
         served_tag_ff   <= served_tag_in;
         served_prio_ff  <= served_prio_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_served_valid  = served_valid_ff;
   assign rsp_served_tag    = served_tag_ff;
   assign rsp_served_prio   = served_prio_ff;
   assign rsp_pending_count = count_ff;

   `SPQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_COUNT, "count overflow")
   `SPQ_ASSERT_NEXT(a_rsp_follows, clock, reset, start, rsp_valid, "missing result")
   `SPQ_ASSERT_NEXT(a_full_drop, clock, reset, start && req_op == OP_INSERT && is_full, count_ff == FULL_COUNT && rsp_status == STATUS_FULL, "full insert not dropped")
   `SPQ_ASSERT_NOW(a_served_ok, clock, reset, rsp_valid && rsp_served_valid, rsp_status == STATUS_OK, "served item with bad status")
   `SPQ_ASSERT_NOW(a_head_order, clock, reset, count_ff >= CNT_BITS'(2), cell_prio[0] <= cell_prio[1], "head out of order")

endmodule
